[src/cubic_bezier_flattener_defines.svh]
// Assertion macros shared by the cubic Bezier flattener RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef CUBIC_BEZIER_FLATTENER_DEFINES_SVH
`define CUBIC_BEZIER_FLATTENER_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define CBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true outside reset.
`define CBF_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[src/cbf_pkg.sv]
// Package of the cubic Bezier flattener: controller states, command and
// status structs, register constants. No dependencies.
`default_nettype none
package cbf_pkg;

  localparam int unsigned SEG_REG_W = 7;
  localparam logic [SEG_REG_W-1:0] SEG_RESET = 7'd16;

  localparam logic CMD_MOVE  = 1'b0;
  localparam logic CMD_CURVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_INIT,
    ST_STEP,
    ST_CHECK,
    ST_DIV,
    ST_OUT
  } cbf_state_e;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic init;
    logic step;
    logic div_start;
    logic emit_curve;
    logic emit_last;
  } cbf_dp_cmd_t;

  typedef struct packed {
    logic at_end;
    logic div_done;
  } cbf_dp_sts_t;

endpackage
`default_nettype wire

[src/cbf_cmd_if.sv]
// Path command channel of the cubic Bezier flattener.
// Valid/ready handshake; no package dependency.
`default_nettype none
interface cbf_cmd_if #(parameter int unsigned W = 16);
  logic                valid;
  logic                ready;
  logic                cmd;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] ctrl1_x;
  logic signed [W-1:0] ctrl1_y;
  logic signed [W-1:0] ctrl2_x;
  logic signed [W-1:0] ctrl2_y;

  modport source (output valid, cmd, point_x, point_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                  input ready);
  modport sink (input valid, cmd, point_x, point_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                output ready);
endinterface
`default_nettype wire

[src/cbf_seg_if.sv]
// Line segment channel of the cubic Bezier flattener.
// Valid/ready handshake; no package dependency.
`default_nettype none
interface cbf_seg_if #(parameter int unsigned W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;
  logic                last;

  modport source (output valid, start_x, start_y, end_x, end_y, last, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, last, output ready);
endinterface
`default_nettype wire

[src/cbf_divider.sv]
// Bit-serial signed floor divider by a positive divisor, one quotient bit
// per cycle. No package dependency.
`default_nettype none
module cbf_divider #(
  parameter int unsigned NW  = 44,
  parameter int unsigned DVW = 22
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic signed [NW-1:0] dividend_i,
  input  wire logic [DVW-1:0]      divisor_i,
  output logic                     done_o,
  output logic signed [NW:0]       quot_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q, quo_d;
  logic [DVW-1:0]  rem_q, rem_d;
  logic [DVW-1:0]  div_q;
  logic            neg_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DVW:0]    trial;
  logic            ge;
  logic signed [NW:0] mag;

  always_comb begin
    trial  = {rem_q, quo_q[NW-1]};
    ge     = (trial >= {1'b0, div_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i[NW-1] ? NW'(-dividend_i) : NW'(dividend_i);
      rem_d  = '0;
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DVW'(trial - {1'b0, div_q}) : DVW'(trial);
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
      neg_q <= dividend_i[NW-1];
    end
  end

  // Negative dividend: floor is minus the magnitude quotient, one lower if inexact.
  assign mag    = $signed({1'b0, quo_q});
  assign quot_o = neg_q ? (-mag - (NW+1)'(rem_q != '0)) : mag;
  assign done_o = done_q;

endmodule
`default_nettype wire

[src/cbf_datapath.sv]
// Datapath of the cubic Bezier flattener: current point, curve coefficients,
// forward differences, two dividers and the segment output register. Uses cbf_pkg.
`default_nettype none
module cbf_datapath import cbf_pkg::*; #(
  parameter int unsigned CW   = 16,
  parameter int unsigned MAXS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [SEG_REG_W-1:0]  seg_cnt_i,
  input  wire logic signed [CW-1:0]  pt_i  [2],
  input  wire logic signed [CW-1:0]  c1_i  [2],
  input  wire logic signed [CW-1:0]  c2_i  [2],
  input  wire cbf_dp_cmd_t           cmd_i,
  output cbf_dp_sts_t                sts_o,
  output logic signed [CW-1:0]       start_o [2],
  output logic signed [CW-1:0]       end_o   [2],
  output logic                       last_o
);

  localparam int unsigned SW   = $clog2(MAXS + 1);
  localparam int unsigned CAW  = CW + 3;
  localparam int unsigned CBW  = CW + 4;
  localparam int unsigned NW   = CW + 8 + 3 * SW;
  localparam int unsigned DVW  = 3 * SW + 1;
  localparam int unsigned SUMW = NW + 2;
  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  logic signed [CW-1:0]  cur_q [2];
  logic signed [CW-1:0]  s_q   [2];
  logic signed [CW-1:0]  e_q   [2];
  logic signed [CW-1:0]  prev_q [2];
  logic signed [CAW-1:0] a_q   [2];
  logic signed [CBW-1:0] b_q   [2];
  logic signed [CAW-1:0] c_q   [2];
  logic signed [NW-1:0]  bn_q  [2];
  logic signed [NW-1:0]  cn2_q [2];
  logic signed [NW-1:0]  f_q   [2];
  logic signed [NW-1:0]  d1_q  [2];
  logic signed [NW-1:0]  d2_q  [2];
  logic signed [NW-1:0]  d3_q  [2];
  logic [SW-1:0]         n_q, k_q, n_sel;
  logic [2*SW-1:0]       nsq_q;
  logic [3*SW-1:0]       d_q;
  logic                  at_end_q;
  logic                  done [2];
  logic signed [NW:0]    quot [2];
  logic signed [CW-1:0]  sat  [2];

  // Segment count: zero means one, clamp to the maximum.
  always_comb begin
    if (seg_cnt_i == '0) begin
      n_sel = SW'(1);
    end else if (seg_cnt_i > SEG_REG_W'(MAXS)) begin
      n_sel = SW'(MAXS);
    end else begin
      n_sel = SW'(seg_cnt_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q[0] <= '0;
      cur_q[1] <= '0;
      at_end_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cur_q[0] <= pt_i[0];
        cur_q[1] <= pt_i[1];
      end
      if (cmd_i.step) begin
        at_end_q <= ((SW+1)'(k_q) + (SW+1)'(1)) == (SW+1)'(n_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) n_q <= n_sel;
    if (cmd_i.mul1) nsq_q <= n_q * n_q;
    if (cmd_i.mul2) d_q <= nsq_q * n_q;
    if (cmd_i.init) k_q <= '0;
    if (cmd_i.step) k_q <= k_q + SW'(1);
    if (cmd_i.emit_curve || cmd_i.emit_last) last_o <= cmd_i.emit_last;
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [CAW-1:0]  da, dc;
    logic signed [CBW-1:0]  db;
    logic signed [NW-1:0]   an;
    logic signed [SUMW-1:0] sum;

    always_comb begin
      da = CAW'(c1_i[l]) - CAW'(c2_i[l]);
      dc = CAW'(c1_i[l]) - CAW'(cur_q[l]);
      db = CBW'(cur_q[l]) - (CBW'(c1_i[l]) <<< 1) + CBW'(c2_i[l]);
      an = NW'(a_q[l]);
      sum = SUMW'(s_q[l]) + SUMW'(quot[l]);
      if (sum > SAT_HI) begin
        sat[l] = CW'(SAT_HI);
      end else if (sum < SAT_LO) begin
        sat[l] = CW'(SAT_LO);
      end else begin
        sat[l] = CW'(sum);
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        s_q[l] <= cur_q[l];
        e_q[l] <= pt_i[l];
        a_q[l] <= CAW'(pt_i[l]) - CAW'(cur_q[l]) + da + (da <<< 1);
        b_q[l] <= db + (db <<< 1);
        c_q[l] <= dc + (dc <<< 1);
      end
      if (cmd_i.mul1) bn_q[l] <= NW'(b_q[l] * $signed({1'b0, n_q}));
      if (cmd_i.mul2) cn2_q[l] <= NW'(c_q[l] * $signed({1'b0, nsq_q}));
      if (cmd_i.init) begin
        f_q[l]    <= '0;
        d1_q[l]   <= an + bn_q[l] + cn2_q[l];
        d2_q[l]   <= (an <<< 2) + (an <<< 1) + (bn_q[l] <<< 1);
        d3_q[l]   <= (an <<< 2) + (an <<< 1);
        prev_q[l] <= s_q[l];
      end
      if (cmd_i.step) begin
        f_q[l]  <= f_q[l] + d1_q[l];
        d1_q[l] <= d1_q[l] + d2_q[l];
        d2_q[l] <= d2_q[l] + d3_q[l];
      end
      if (cmd_i.emit_curve) begin
        start_o[l] <= prev_q[l];
        end_o[l]   <= sat[l];
        prev_q[l]  <= sat[l];
      end
      if (cmd_i.emit_last) begin
        start_o[l] <= prev_q[l];
        end_o[l]   <= e_q[l];
      end
    end

    // Round to nearest: floor((2*num + N^3) / (2*N^3)).
    cbf_divider #(.NW(NW), .DVW(DVW)) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (cmd_i.div_start),
      .dividend_i ((f_q[l] <<< 1) + NW'($signed({1'b0, d_q}))),
      .divisor_i  ({d_q, 1'b0}),
      .done_o     (done[l]),
      .quot_o     (quot[l])
    );
  end

  assign sts_o.at_end   = at_end_q;
  assign sts_o.div_done = done[0] & done[1];

endmodule
`default_nettype wire

[src/cbf_ctrl.sv]
// Controller of the cubic Bezier flattener: sequences setup, point steps,
// division and segment hand-off. Uses cbf_pkg and the assertion macros.
`default_nettype none
`include "cubic_bezier_flattener_defines.svh"
module cbf_ctrl import cbf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_curve_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire cbf_dp_sts_t sts_i,
  output cbf_dp_cmd_t      cmd_o
);

  cbf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_curve_i == CMD_CURVE) state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.at_end) begin
          cmd_o.emit_last = 1'b1;
          state_d         = ST_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.emit_curve = 1'b1;
          state_d          = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = sts_i.at_end ? ST_IDLE : ST_STEP;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `CBF_ASSERT(a_done_in_div, sts_i.div_done |-> state_q == ST_DIV, "divider finished outside divide wait")

endmodule
`default_nettype wire

[src/cubic_bezier_flattener.sv]
// Top level of the cubic Bezier flattener: controller, datapath and the
// segment count register. Uses cbf_pkg, cbf_cmd_if, cbf_seg_if and the macros.
`default_nettype none
`include "cubic_bezier_flattener_defines.svh"
// A move item loads the current point and emits nothing. A curve item emits N
// segments, N being segment_count (zero reads as one, values above MAX_SEGMENTS
// read as MAX_SEGMENTS). Setup runs through the load and the MUL1, MUL2 and
// INIT states; each inner point then takes a step, a check and a wait on the
// divider, then waits in the output state until the segment is taken; the last
// segment skips the divider. The serial divider that rounds each point works
// through an NW-bit dividend one bit at a time and so sets the pace, where
// NW = COORD_WIDTH + 8 + 3*ceil(log2(MAX_SEGMENTS+1)). One item is worked on
// at a time: the command channel is ready only while no segment is pending.
module cubic_bezier_flattener import cbf_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 segment_count_we_i,
  input  wire logic [SEG_REG_W-1:0] segment_count_i,
  cbf_cmd_if.sink                   cmd_i,
  cbf_seg_if.source                 seg_o
);

  logic [SEG_REG_W-1:0]          seg_cnt_q;
  cbf_dp_cmd_t                   dp_cmd;
  cbf_dp_sts_t                   dp_sts;
  logic signed [COORD_WIDTH-1:0] pt [2];
  logic signed [COORD_WIDTH-1:0] c1 [2];
  logic signed [COORD_WIDTH-1:0] c2 [2];
  logic signed [COORD_WIDTH-1:0] seg_start [2];
  logic signed [COORD_WIDTH-1:0] seg_end   [2];

  // Hold the segment count; the user must write it only while idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_cnt_q <= SEG_RESET;
    end else if (segment_count_we_i) begin
      seg_cnt_q <= segment_count_i;
    end
  end

  assign pt[0] = cmd_i.point_x;
  assign pt[1] = cmd_i.point_y;
  assign c1[0] = cmd_i.ctrl1_x;
  assign c1[1] = cmd_i.ctrl1_y;
  assign c2[0] = cmd_i.ctrl2_x;
  assign c2[1] = cmd_i.ctrl2_y;

  cbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_curve_i  (cmd_i.cmd),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (seg_o.valid),
    .out_ready_i (seg_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  cbf_datapath #(.CW(COORD_WIDTH), .MAXS(MAX_SEGMENTS)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seg_cnt_i (seg_cnt_q),
    .pt_i      (pt),
    .c1_i      (c1),
    .c2_i      (c2),
    .cmd_i     (dp_cmd),
    .sts_o     (dp_sts),
    .start_o   (seg_start),
    .end_o     (seg_end),
    .last_o    (seg_o.last)
  );

  assign seg_o.start_x = seg_start[0];
  assign seg_o.start_y = seg_start[1];
  assign seg_o.end_x   = seg_end[0];
  assign seg_o.end_y   = seg_end[1];

  // A pending segment blocks new commands; the final segment reopens the channel.
  `CBF_ASSERT_NEVER(a_in_out_excl, cmd_i.ready && seg_o.valid, "command taken with segment pending")
  `CBF_ASSERT(a_last_to_idle, seg_o.valid && seg_o.ready && seg_o.last |=> cmd_i.ready, "no idle after last segment")

endmodule
`default_nettype wire
